/* rtl/cbc_pkg.sv */
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared widths, codes and control types of the colour blob centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

package cbc_pkg;

    localparam int PIX_W    = 8;
    localparam int CLASS_W  = 2;
    localparam int CENTER_W = 10;
    localparam int CNT_W    = 21;
    localparam int SUM_W    = 30;
    localparam int FW_W     = 11;
    localparam int THR_W    = 8;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;
    localparam int SEL_W    = 2;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam logic [CLASS_W-1:0] CLASS_NONE  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_BLUE  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_GREEN = 2'd2;

    localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [1:0] REG_BRIGHT      = 2'd1;
    localparam logic [1:0] REG_DARK        = 2'd2;

    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST = 11'd640;
    localparam logic [THR_W-1:0] BRIGHT_RST      = 8'd130;
    localparam logic [THR_W-1:0] DARK_RST        = 8'd100;

    localparam logic [PIX_W-1:0]    PIX_FULL   = 8'd255;
    localparam logic [CNT_W-1:0]    COUNT_MAX  = 21'h1FFFFF;
    localparam logic [SUM_W-1:0]    SUM_MAX    = 30'h3FFFFFFF;
    localparam logic [CENTER_W-1:0] CENTER_MAX = 10'd1023;

    // order in which the four quotients are worked out
    localparam logic [SEL_W-1:0] SEL_BLUE_X  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_BLUE_Y  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_GREEN_X = 2'd2;
    localparam logic [SEL_W-1:0] SEL_GREEN_Y = 2'd3;

    typedef struct packed {
        logic             accept;
        logic             div_start;
        logic [SEL_W-1:0] div_sel;
        logic             div_store;
        logic             load_frame;
    } cmd_t;

    typedef struct packed {
        logic out_valid;
        logic last;
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

/* rtl/cbc_pixel_if.sv */
// ----------------------------------------------------------------------------
// cbc_pixel_if
// Pixel request channel: valid, ready and one RGB pixel with frame end mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbc_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [cbc_pkg::PIX_W-1:0] pixel_blue;
    logic [cbc_pkg::PIX_W-1:0] pixel_green;
    logic [cbc_pkg::PIX_W-1:0] pixel_red;
    logic                      last_in_frame;

    modport source (output valid, pixel_blue, pixel_green, pixel_red, last_in_frame,
                    input ready);
    modport sink   (input valid, pixel_blue, pixel_green, pixel_red, last_in_frame,
                    output ready);
endinterface

`default_nettype wire

/* rtl/cbc_result_if.sv */
// ----------------------------------------------------------------------------
// cbc_result_if
// Result request channel: recoloured pixel, class and frame centroids.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbc_result_if;
    logic                         valid;
    logic                         ready;
    logic [cbc_pkg::PIX_W-1:0]    out_blue;
    logic [cbc_pkg::PIX_W-1:0]    out_green;
    logic [cbc_pkg::PIX_W-1:0]    out_red;
    logic [cbc_pkg::CLASS_W-1:0]  pixel_class;
    logic                         frame_done;
    logic                         blue_found;
    logic [cbc_pkg::CENTER_W-1:0] blue_center_x;
    logic [cbc_pkg::CENTER_W-1:0] blue_center_y;
    logic                         green_found;
    logic [cbc_pkg::CENTER_W-1:0] green_center_x;
    logic [cbc_pkg::CENTER_W-1:0] green_center_y;

    modport source (output valid, out_blue, out_green, out_red, pixel_class, frame_done,
                    blue_found, blue_center_x, blue_center_y,
                    green_found, green_center_x, green_center_y,
                    input ready);
    modport sink   (input valid, out_blue, out_green, out_red, pixel_class, frame_done,
                    blue_found, blue_center_x, blue_center_y,
                    green_found, green_center_x, green_center_y,
                    output ready);
endinterface

`default_nettype wire

/* rtl/color_blob_centroid.sv */
// ----------------------------------------------------------------------------
// color_blob_centroid
// Colour threshold blob detector with per-class centroids at frame end.
//
// pix carries RGB pixels in raster order with a frame end mark; res returns
// each pixel recoloured to pure blue or pure green when it matches, with its
// class. On the last pixel of a frame res also carries the found flags and
// the floor-mean column and row of each class, and the sums are cleared.
// Ordinary pixels: a result is registered in the cycle after its pixel is
// taken, and a new pixel is taken every clock while res keeps up. The
// frame end pixel starts four divisions on one shared restoring divider
// of one quotient bit per cycle; pix is not ready until its result is
// loaded. When res stalls, the result register holds and pix is not ready.
// Reset loads width 640 and thresholds 130 and 100 and clears all sums and
// position counters. Registers sit on the APB port at 0x0, 0x4 and 0x8.
// ----------------------------------------------------------------------------
`default_nettype none

module color_blob_centroid #(
    parameter int MAX_WIDTH  = cbc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cbc_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    cbc_pixel_if.sink                         pix,
    cbc_result_if.source                      res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cbc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [cbc_pkg::DATA_W-1:0]   pwdata,
    output logic [cbc_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    logic [cbc_pkg::FW_W-1:0]  frame_width_reg;
    logic [cbc_pkg::THR_W-1:0] bright_reg;
    logic [cbc_pkg::THR_W-1:0] dark_reg;

    logic [1:0]                reg_index;
    logic                      cfg_write;

    cbc_pkg::cmd_t             cmd;
    cbc_pkg::status_t          status;
    logic [cbc_pkg::SUM_W-1:0] div_dividend;
    logic [cbc_pkg::CNT_W-1:0] div_divisor;
    logic [cbc_pkg::SUM_W-1:0] div_quotient;
    logic                      div_busy;
    logic                      div_done;

    assign pready    = 1'b1;
    assign reg_index = paddr[cbc_pkg::ADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= cbc_pkg::FRAME_WIDTH_RST;
            bright_reg      <= cbc_pkg::BRIGHT_RST;
            dark_reg        <= cbc_pkg::DARK_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                cbc_pkg::REG_FRAME_WIDTH: frame_width_reg <= pwdata[cbc_pkg::FW_W-1:0];
                cbc_pkg::REG_BRIGHT:      bright_reg      <= pwdata[cbc_pkg::THR_W-1:0];
                cbc_pkg::REG_DARK:        dark_reg        <= pwdata[cbc_pkg::THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            cbc_pkg::REG_FRAME_WIDTH: prdata = cbc_pkg::DATA_W'(frame_width_reg);
            cbc_pkg::REG_BRIGHT:      prdata = cbc_pkg::DATA_W'(bright_reg);
            cbc_pkg::REG_DARK:        prdata = cbc_pkg::DATA_W'(dark_reg);
            default:                  prdata = '0;
        endcase
    end

    always_comb
    begin
        status.out_valid = res.valid;
        status.last      = pix.last_in_frame;
        status.div_done  = div_done;
    end

    cbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cbc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    cbc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .pixel_blue       (pix.pixel_blue),
        .pixel_green      (pix.pixel_green),
        .pixel_red        (pix.pixel_red),
        .last_in_frame    (pix.last_in_frame),
        .frame_width      (frame_width_reg),
        .bright_threshold (bright_reg),
        .dark_threshold   (dark_reg),
        .div_dividend     (div_dividend),
        .div_divisor      (div_divisor),
        .div_quotient     (div_quotient),
        .out_ready        (res.ready),
        .out_valid        (res.valid),
        .out_blue         (res.out_blue),
        .out_green        (res.out_green),
        .out_red          (res.out_red),
        .pixel_class      (res.pixel_class),
        .frame_done       (res.frame_done),
        .blue_found       (res.blue_found),
        .blue_center_x    (res.blue_center_x),
        .blue_center_y    (res.blue_center_y),
        .green_found      (res.green_found),
        .green_center_x   (res.green_center_x),
        .green_center_y   (res.green_center_y)
    );

`ifndef NO_ASSERTIONS
    // no pixel is taken while the frame end divisions run
    assert property (@(posedge clk) disable iff (!rst_n) div_busy |-> !pix.ready)
        else $error("pixel request taken during frame end division");

    // the frame end pixel closes the input until its result is loaded
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready && pix.last_in_frame) |=> !pix.ready)
        else $error("input still open after frame end pixel");

    // an empty blue class reports a zero centre
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.blue_found) |->
        (res.blue_center_x == '0 && res.blue_center_y == '0))
        else $error("blue centre set without blue pixels");

    // divider start never lands on a running division
    assert property (@(posedge clk) disable iff (!rst_n) cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire

/* rtl/cbc_divider.sv */
// ----------------------------------------------------------------------------
// cbc_divider
// Restoring divider, one quotient bit per cycle, sum by pixel count.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_divider (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [cbc_pkg::SUM_W-1:0]   dividend,
    input  wire logic [cbc_pkg::CNT_W-1:0]   divisor,
    output logic                             busy,
    output logic                             done,
    output logic [cbc_pkg::SUM_W-1:0]        quotient
);

    localparam int STEP_W = $clog2(cbc_pkg::SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(cbc_pkg::SUM_W - 1);

    logic [STEP_W-1:0]           step_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [cbc_pkg::SUM_W-1:0]   dvd_reg;
    logic [cbc_pkg::CNT_W-1:0]   dvs_reg;
    logic [cbc_pkg::CNT_W-1:0]   rem_reg;
    logic [cbc_pkg::SUM_W-1:0]   quot_reg;

    logic [cbc_pkg::CNT_W:0]     rem_shift;
    logic                        fits;
    logic [cbc_pkg::CNT_W-1:0]   rem_next;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[cbc_pkg::SUM_W-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        if (fits)
        begin
            rem_next = cbc_pkg::CNT_W'(rem_shift - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = rem_shift[cbc_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[cbc_pkg::SUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[cbc_pkg::SUM_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

/* rtl/cbc_ctrl.sv */
// ----------------------------------------------------------------------------
// cbc_ctrl
// Sequencer: pixel acceptance, the four frame-end divisions, result loading.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              out_ready,
    input  wire cbc_pkg::status_t  status,
    output cbc_pkg::cmd_t          cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t                      state_reg;
    logic                        start_reg;
    logic [cbc_pkg::SEL_W-1:0]   sel_reg;

    logic out_blocked;
    logic accept;

    always_comb
    begin
        out_blocked    = status.out_valid & ~out_ready;
        in_ready       = (state_reg == ST_IDLE) & ~out_blocked;
        accept         = in_valid & in_ready;
        cmd.accept     = accept;
        cmd.div_start  = start_reg;
        cmd.div_sel    = sel_reg;
        cmd.div_store  = (state_reg == ST_DIVIDE) & status.div_done;
        cmd.load_frame = (state_reg == ST_FINISH) & ~out_blocked;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
            sel_reg   <= cbc_pkg::SEL_BLUE_X;
        end
        else
        begin
            start_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && status.last)
                    begin
                        state_reg <= ST_DIVIDE;
                        start_reg <= 1'b1;
                        sel_reg   <= cbc_pkg::SEL_BLUE_X;
                    end
                end
                ST_DIVIDE:
                begin
                    if (status.div_done)
                    begin
                        if (sel_reg == cbc_pkg::SEL_GREEN_Y)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            sel_reg   <= sel_reg + 1'b1;
                            start_reg <= 1'b1;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (!out_blocked)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/cbc_datapath.sv */
// ----------------------------------------------------------------------------
// cbc_datapath
// Classifier, position counters, moment accumulators and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbc_datapath #(
    parameter int MAX_WIDTH  = cbc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cbc_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cbc_pkg::cmd_t                 cmd,
    input  wire logic [cbc_pkg::PIX_W-1:0]     pixel_blue,
    input  wire logic [cbc_pkg::PIX_W-1:0]     pixel_green,
    input  wire logic [cbc_pkg::PIX_W-1:0]     pixel_red,
    input  wire logic                          last_in_frame,
    input  wire logic [cbc_pkg::FW_W-1:0]      frame_width,
    input  wire logic [cbc_pkg::THR_W-1:0]     bright_threshold,
    input  wire logic [cbc_pkg::THR_W-1:0]     dark_threshold,
    output logic [cbc_pkg::SUM_W-1:0]          div_dividend,
    output logic [cbc_pkg::CNT_W-1:0]          div_divisor,
    input  wire logic [cbc_pkg::SUM_W-1:0]     div_quotient,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [cbc_pkg::PIX_W-1:0]          out_blue,
    output logic [cbc_pkg::PIX_W-1:0]          out_green,
    output logic [cbc_pkg::PIX_W-1:0]          out_red,
    output logic [cbc_pkg::CLASS_W-1:0]        pixel_class,
    output logic                               frame_done,
    output logic                               blue_found,
    output logic [cbc_pkg::CENTER_W-1:0]       blue_center_x,
    output logic [cbc_pkg::CENTER_W-1:0]       blue_center_y,
    output logic                               green_found,
    output logic [cbc_pkg::CENTER_W-1:0]       green_center_x,
    output logic [cbc_pkg::CENTER_W-1:0]       green_center_y
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int EW    = (COL_W + 1 > cbc_pkg::FW_W) ? COL_W + 1 : cbc_pkg::FW_W;
    localparam logic [EW-1:0]    WIDTH_LIMIT = EW'(MAX_WIDTH);
    localparam logic [ROW_W-1:0] ROW_LAST    = ROW_W'(MAX_HEIGHT - 1);
    localparam int SW = cbc_pkg::SUM_W + 1;

    logic [COL_W-1:0]             col_reg;
    logic [ROW_W-1:0]             row_reg;
    logic [cbc_pkg::CNT_W-1:0]    blue_pixels_reg, green_pixels_reg;
    logic [cbc_pkg::SUM_W-1:0]    blue_sum_x_reg, blue_sum_y_reg;
    logic [cbc_pkg::SUM_W-1:0]    green_sum_x_reg, green_sum_y_reg;
    logic [cbc_pkg::CENTER_W-1:0] quot_reg [4];

    logic [cbc_pkg::PIX_W-1:0]    hold_blue_reg, hold_green_reg, hold_red_reg;
    logic [cbc_pkg::CLASS_W-1:0]  hold_class_reg;

    logic                         valid_reg;
    logic [cbc_pkg::PIX_W-1:0]    res_blue_reg, res_green_reg, res_red_reg;
    logic [cbc_pkg::CLASS_W-1:0]  res_class_reg;
    logic                         res_done_reg;
    logic                         res_bfound_reg, res_gfound_reg;
    logic [cbc_pkg::CENTER_W-1:0] res_bx_reg, res_by_reg, res_gx_reg, res_gy_reg;

    logic                         is_blue, is_green;
    logic [cbc_pkg::CLASS_W-1:0]  cls;
    logic [cbc_pkg::PIX_W-1:0]    new_blue, new_green, new_red;
    logic [EW-1:0]                width_eff, fw_ext;
    logic                         line_end;
    logic [SW-1:0]                add_x, add_y;
    logic [cbc_pkg::SUM_W-1:0]    sum_x_next, sum_y_next;
    logic                         load_pixel;
    logic [cbc_pkg::CENTER_W-1:0] quot_clamped;
    logic                         bfound, gfound;

    always_comb
    begin
        is_blue  = (pixel_blue > bright_threshold) && (pixel_red < dark_threshold)
                   && (pixel_green < dark_threshold);
        is_green = (pixel_green > bright_threshold) && (pixel_red < dark_threshold)
                   && (pixel_blue < dark_threshold);
        priority if (is_blue)
        begin
            cls       = cbc_pkg::CLASS_BLUE;
            new_blue  = cbc_pkg::PIX_FULL;
            new_green = '0;
            new_red   = '0;
        end
        else if (is_green)
        begin
            cls       = cbc_pkg::CLASS_GREEN;
            new_blue  = '0;
            new_green = cbc_pkg::PIX_FULL;
            new_red   = '0;
        end
        else
        begin
            cls       = cbc_pkg::CLASS_NONE;
            new_blue  = pixel_blue;
            new_green = pixel_green;
            new_red   = pixel_red;
        end

        // zero width acts as one, oversize as the maximum
        fw_ext = EW'(frame_width);
        priority if (fw_ext == '0)
        begin
            width_eff = EW'(1);
        end
        else if (fw_ext > WIDTH_LIMIT)
        begin
            width_eff = WIDTH_LIMIT;
        end
        else
        begin
            width_eff = fw_ext;
        end
        line_end = (EW'(col_reg) + EW'(1)) >= width_eff;

        // one shared saturating adder pair, the class picks the accumulators
        if (is_blue)
        begin
            add_x = {1'b0, blue_sum_x_reg} + SW'(col_reg);
            add_y = {1'b0, blue_sum_y_reg} + SW'(row_reg);
        end
        else
        begin
            add_x = {1'b0, green_sum_x_reg} + SW'(col_reg);
            add_y = {1'b0, green_sum_y_reg} + SW'(row_reg);
        end
        sum_x_next = add_x[SW-1] ? cbc_pkg::SUM_MAX : add_x[cbc_pkg::SUM_W-1:0];
        sum_y_next = add_y[SW-1] ? cbc_pkg::SUM_MAX : add_y[cbc_pkg::SUM_W-1:0];

        load_pixel = cmd.accept & ~last_in_frame;

        unique case (cmd.div_sel)
            cbc_pkg::SEL_BLUE_X:
            begin
                div_dividend = blue_sum_x_reg;
                div_divisor  = blue_pixels_reg;
            end
            cbc_pkg::SEL_BLUE_Y:
            begin
                div_dividend = blue_sum_y_reg;
                div_divisor  = blue_pixels_reg;
            end
            cbc_pkg::SEL_GREEN_X:
            begin
                div_dividend = green_sum_x_reg;
                div_divisor  = green_pixels_reg;
            end
            default:
            begin
                div_dividend = green_sum_y_reg;
                div_divisor  = green_pixels_reg;
            end
        endcase

        if (div_quotient[cbc_pkg::SUM_W-1:cbc_pkg::CENTER_W] != '0)
        begin
            quot_clamped = cbc_pkg::CENTER_MAX;
        end
        else
        begin
            quot_clamped = div_quotient[cbc_pkg::CENTER_W-1:0];
        end

        bfound = blue_pixels_reg != '0;
        gfound = green_pixels_reg != '0;
    end

    // position counters and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg          <= '0;
            row_reg          <= '0;
            blue_pixels_reg  <= '0;
            blue_sum_x_reg   <= '0;
            blue_sum_y_reg   <= '0;
            green_pixels_reg <= '0;
            green_sum_x_reg  <= '0;
            green_sum_y_reg  <= '0;
        end
        else if (cmd.load_frame)
        begin
            col_reg          <= '0;
            row_reg          <= '0;
            blue_pixels_reg  <= '0;
            blue_sum_x_reg   <= '0;
            blue_sum_y_reg   <= '0;
            green_pixels_reg <= '0;
            green_sum_x_reg  <= '0;
            green_sum_y_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            if (is_blue)
            begin
                if (blue_pixels_reg != cbc_pkg::COUNT_MAX)
                begin
                    blue_pixels_reg <= blue_pixels_reg + 1'b1;
                end
                blue_sum_x_reg <= sum_x_next;
                blue_sum_y_reg <= sum_y_next;
            end
            else if (is_green)
            begin
                if (green_pixels_reg != cbc_pkg::COUNT_MAX)
                begin
                    green_pixels_reg <= green_pixels_reg + 1'b1;
                end
                green_sum_x_reg <= sum_x_next;
                green_sum_y_reg <= sum_y_next;
            end
            if (!last_in_frame)
            begin
                if (line_end)
                begin
                    col_reg <= '0;
                    if (row_reg != ROW_LAST)
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    // frame end pixel and quotients wait here while the divider runs
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hold_blue_reg  <= new_blue;
            hold_green_reg <= new_green;
            hold_red_reg   <= new_red;
            hold_class_reg <= cls;
        end
        if (cmd.div_store)
        begin
            quot_reg[cmd.div_sel] <= quot_clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_pixel || cmd.load_frame)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pixel)
        begin
            res_blue_reg   <= new_blue;
            res_green_reg  <= new_green;
            res_red_reg    <= new_red;
            res_class_reg  <= cls;
            res_done_reg   <= 1'b0;
            res_bfound_reg <= 1'b0;
            res_bx_reg     <= '0;
            res_by_reg     <= '0;
            res_gfound_reg <= 1'b0;
            res_gx_reg     <= '0;
            res_gy_reg     <= '0;
        end
        else if (cmd.load_frame)
        begin
            res_blue_reg   <= hold_blue_reg;
            res_green_reg  <= hold_green_reg;
            res_red_reg    <= hold_red_reg;
            res_class_reg  <= hold_class_reg;
            res_done_reg   <= 1'b1;
            res_bfound_reg <= bfound;
            res_bx_reg     <= bfound ? quot_reg[cbc_pkg::SEL_BLUE_X] : '0;
            res_by_reg     <= bfound ? quot_reg[cbc_pkg::SEL_BLUE_Y] : '0;
            res_gfound_reg <= gfound;
            res_gx_reg     <= gfound ? quot_reg[cbc_pkg::SEL_GREEN_X] : '0;
            res_gy_reg     <= gfound ? quot_reg[cbc_pkg::SEL_GREEN_Y] : '0;
        end
    end

    assign out_valid      = valid_reg;
    assign out_blue       = res_blue_reg;
    assign out_green      = res_green_reg;
    assign out_red        = res_red_reg;
    assign pixel_class    = res_class_reg;
    assign frame_done     = res_done_reg;
    assign blue_found     = res_bfound_reg;
    assign blue_center_x  = res_bx_reg;
    assign blue_center_y  = res_by_reg;
    assign green_found    = res_gfound_reg;
    assign green_center_x = res_gx_reg;
    assign green_center_y = res_gy_reg;

endmodule

`default_nettype wire
